// ===== src/lsc_pkg.sv =====
// Shared constants, types and status structs of the LRU slot cache.
package lsc_pkg;

  localparam int ENTRIES     = 16;
  localparam int KEY_BITS    = 32;
  localparam int SLOT_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int KEY_PORT_W  = 32;
  localparam int SLOT_PORT_W = 4;

  typedef logic [KEY_BITS-1:0] tag_t;
  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [RANK_W-1:0]   rank_t;

  // Sequencer to scan unit
  typedef struct packed {
    logic  start;
    logic  step;
    slot_t idx;
  } scan_ctl_t;

  // Running result of a scan over the slots
  typedef struct packed {
    logic  found;
    slot_t hit_slot;
    rank_t hit_rank;
    logic  empty;
    slot_t empty_slot;
    logic  best_any;
    slot_t best_slot;
    rank_t best_rank;
    tag_t  best_tag;
  } scan_res_t;

endpackage

// ===== src/lsc_key_if.sv =====
// Request channel: one key per beat.
interface lsc_key_if;
  logic                             valid;
  logic                             ready;
  logic [lsc_pkg::KEY_PORT_W-1:0]   key;

  modport source (output valid, output key, input ready);
  modport sink   (input valid, input key, output ready);
endinterface

// ===== src/lsc_res_if.sv =====
// Response channel: lookup result per beat.
interface lsc_res_if;
  logic                             valid;
  logic                             ready;
  logic                             hit;
  logic [lsc_pkg::SLOT_PORT_W-1:0]  slot;
  logic                             evicted_valid;
  logic [lsc_pkg::KEY_PORT_W-1:0]   evicted_key;

  modport source (output valid, output hit, output slot, output evicted_valid,
                  output evicted_key, input ready);
  modport sink   (input valid, input hit, input slot, input evicted_valid,
                  input evicted_key, output ready);
endinterface

// ===== src/lru_slot_cache.sv =====
// Top level of the LRU slot cache: tag store, recency ranks and sequencer.
//
// Fully associative tag store with least-recently-used replacement.
// req carries one key per beat; rsp returns one beat per key with hit, the
// slot now holding the key, and the evicted key (with its flag) on a miss
// that replaced a valid entry. On a miss the requester refills that slot.
//
// Timing: a key is taken while the sequencer is idle, then the scan unit
// visits one slot per cycle, then a commit step updates ranks, valid bits
// and the tag and loads the response register. The next key is taken only
// after that commit, so keys do not overlap. req.ready is high only while
// the sequencer is idle.
//
// The response sits in an output register, so a new key is taken while the
// previous response still waits. If rsp is stalled, the next commit waits in
// place until the output register frees up.
//
// Reset (synchronous, rst high) clears valid bits, ranks and the sequencer;
// the tag store is not cleared, its entries are only read where valid.
module lru_slot_cache (
  input  logic      clk,
  input  logic      rst,
  lsc_key_if.sink   req,
  lsc_res_if.source rsp
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_COMMIT} state_t;

  localparam lsc_pkg::slot_t LAST_IDX = lsc_pkg::SLOT_W'(lsc_pkg::ENTRIES - 1);

  state_t                        state;
  lsc_pkg::slot_t                idx;
  lsc_pkg::tag_t                 key_r;
  lsc_pkg::tag_t                 tag_store [lsc_pkg::ENTRIES];
  logic [lsc_pkg::ENTRIES-1:0]   valid_bits;
  lsc_pkg::rank_t                rank [lsc_pkg::ENTRIES];

  lsc_pkg::scan_ctl_t            scan_ctl;
  lsc_pkg::scan_res_t            scan_res;

  logic                          req_fire;
  logic                          rsp_free;
  logic                          commit;
  lsc_pkg::slot_t                sel_slot;
  lsc_pkg::rank_t                old_rank;
  logic                          age_all;
  logic                          evict;

  assign req.ready = (state == ST_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign rsp_free  = !rsp.valid || rsp.ready;
  assign commit    = (state == ST_COMMIT) && rsp_free;

  // scan control: clear on accept, step once per slot
  assign scan_ctl.start = req_fire;
  assign scan_ctl.step  = (state == ST_SCAN);
  assign scan_ctl.idx   = idx;

  lsc_scan u_scan (
    .clk  (clk),
    .rst  (rst),
    .ctl  (scan_ctl),
    .key  (key_r),
    .tag  (tag_store[idx]),
    .vld  (valid_bits[idx]),
    .rank (rank[idx]),
    .res  (scan_res)
  );

  // Replacement decision: hit slot, else first empty slot, else oldest.
  always_comb begin
    evict    = !scan_res.found && !scan_res.empty;
    age_all  = !scan_res.found && scan_res.empty;   // new entry: every valid slot ages
    old_rank = scan_res.found ? scan_res.hit_rank : scan_res.best_rank;
    if (scan_res.found) begin
      sel_slot = scan_res.hit_slot;
    end else if (scan_res.empty) begin
      sel_slot = scan_res.empty_slot;
    end else begin
      sel_slot = scan_res.best_slot;
    end
  end

  // Tag store: written only when a key is installed
  always_ff @(posedge clk) begin
    if (commit && !scan_res.found) begin
      tag_store[sel_slot] <= key_r;
    end
  end

  // Sequencer, recency ranks, valid bits and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      idx        <= '0;
      valid_bits <= '0;
      rsp.valid  <= 1'b0;
      for (int i = 0; i < lsc_pkg::ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else begin
      // a commit reloads the output register, else a taken beat empties it
      if (commit) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_fire) begin
            key_r <= lsc_pkg::tag_t'(req.key);
            idx   <= '0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          idx <= idx + lsc_pkg::SLOT_W'(1);
          if (idx == LAST_IDX) begin
            state <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          if (rsp_free) begin
            // slots more recent than the selected one age by one; on a fill of an empty slot every valid slot ages
            for (int i = 0; i < lsc_pkg::ENTRIES; i++) begin
              if (lsc_pkg::SLOT_W'(i) != sel_slot && valid_bits[i] &&
                  (age_all || rank[i] < old_rank)) begin
                rank[i] <= rank[i] + lsc_pkg::RANK_W'(1);
              end
            end
            rank[sel_slot]       <= '0;
            valid_bits[sel_slot] <= 1'b1;
            rsp.hit              <= scan_res.found;
            rsp.slot             <= lsc_pkg::SLOT_PORT_W'(sel_slot);
            rsp.evicted_valid    <= evict;
            rsp.evicted_key      <= evict ? lsc_pkg::KEY_PORT_W'(scan_res.best_tag)
                                          : '0;
            state                <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // Selected slot is valid and most recent after a commit.
  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    commit |=> valid_bits[$past(sel_slot)])
    else $error("committed slot not valid");

  a_commit_rank: assert property (@(posedge clk) disable iff (rst)
    commit |=> rank[$past(sel_slot)] == '0)
    else $error("committed slot not most recent");

  // Eviction only when every slot holds a key.
  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    (commit && evict) |-> (&valid_bits))
    else $error("eviction with an empty slot present");

  // Valid bits are only ever set outside reset.
  a_valid_grow: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> $countones(valid_bits) >= $countones($past(valid_bits)))
    else $error("valid count dropped");
`endif

endmodule

// ===== src/lsc_scan.sv =====
// Scan unit: examines one slot per step, tracks hit, first empty and oldest slot.
module lsc_scan (
  input  logic               clk,
  input  logic               rst,
  input  lsc_pkg::scan_ctl_t ctl,
  input  lsc_pkg::tag_t      key,
  input  lsc_pkg::tag_t      tag,
  input  logic               vld,
  input  lsc_pkg::rank_t     rank,
  output lsc_pkg::scan_res_t res
);

  always_ff @(posedge clk) begin
    if (rst || ctl.start) begin
      res <= '0;
    end else if (ctl.step) begin
      // first match wins
      if (vld && tag == key && !res.found) begin
        res.found    <= 1'b1;
        res.hit_slot <= ctl.idx;
        res.hit_rank <= rank;
      end
      if (!vld && !res.empty) begin
        res.empty      <= 1'b1;
        res.empty_slot <= ctl.idx;
      end
      // strict compare keeps the lowest slot on a tie
      if (vld && (!res.best_any || rank > res.best_rank)) begin
        res.best_any  <= 1'b1;
        res.best_slot <= ctl.idx;
        res.best_rank <= rank;
        res.best_tag  <= tag;
      end
    end
  end

endmodule

// ===== tb/sv/tb_lru_slot_cache.sv =====
// Self-checking testbench of lru_slot_cache: shadow LRU tag store, paced request/response beats.
module tb_lru_slot_cache;
  timeunit 1ns;
  timeprecision 1ps;

  // Random part: eight working-set phases of PHASE_ITEMS keys each.
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 228;
  localparam int LONG_HOLD    = 400;              // response-side hold-off, cycles
  localparam int DRAIN_CYCLES = 3 * (lsc_pkg::ENTRIES + 2); // a few key latencies

  // One expected response beat.
  typedef struct packed {
    logic                            hit;
    logic [lsc_pkg::SLOT_PORT_W-1:0] slot;
    logic                            ev_valid;
    logic [lsc_pkg::KEY_PORT_W-1:0]  ev_key;
  } lookup_res_t;

  // Shadow copy of the tag store and recency ranks. Every accepted key is
  // looked up here right away, and the response it must produce is queued.
  class lru_shadow;
    lsc_pkg::tag_t  held_key [lsc_pkg::ENTRIES];
    bit             present  [lsc_pkg::ENTRIES];
    lsc_pkg::rank_t age_rank [lsc_pkg::ENTRIES];
    lookup_res_t    pending_lookups [$];
    int             mismatches;
    int             beats_seen;

    function new();
      for (int i = 0; i < lsc_pkg::ENTRIES; i++) begin
        held_key[i] = '0;
        present[i]  = 1'b0;
        age_rank[i] = '0;
      end
      mismatches = 0;
      beats_seen = 0;
    endfunction

    function int pending();
      return pending_lookups.size();
    endfunction

    // Slot s becomes most recent; valid slots ranked ahead of its old rank
    // age by one. A fresh fill passes ENTRIES so every valid slot ages.
    function void make_newest(int s, int old_rank);
      for (int i = 0; i < lsc_pkg::ENTRIES; i++) begin
        if (i != s && present[i] && int'(age_rank[i]) < old_rank) begin
          age_rank[i] = age_rank[i] + 1'b1;
        end
      end
      age_rank[s] = '0;
    endfunction

    function void note_key(logic [lsc_pkg::KEY_PORT_W-1:0] k);
      lsc_pkg::tag_t t;
      lookup_res_t   r;
      int            s;
      int            victim;
      bit            found;
      bit            empty;
      t      = lsc_pkg::tag_t'(k);   // only the low KEY_BITS take part
      r      = '0;
      s      = 0;
      found  = 1'b0;
      empty  = 1'b0;
      for (int i = 0; i < lsc_pkg::ENTRIES; i++) begin
        if (!found && present[i] && held_key[i] == t) begin
          s     = i;
          found = 1'b1;
        end
      end
      if (found) begin
        make_newest(s, int'(age_rank[s]));
      end else begin
        // lowest free slot first
        for (int i = 0; i < lsc_pkg::ENTRIES; i++) begin
          if (!empty && !present[i]) begin
            s     = i;
            empty = 1'b1;
          end
        end
        if (empty) begin
          make_newest(s, lsc_pkg::ENTRIES);
        end else begin
          // store full: oldest rank goes, lowest index on a tie
          victim = 0;
          for (int i = 1; i < lsc_pkg::ENTRIES; i++) begin
            if (age_rank[i] > age_rank[victim]) victim = i;
          end
          s          = victim;
          r.ev_valid = 1'b1;
          r.ev_key   = lsc_pkg::KEY_PORT_W'(held_key[s]);
          make_newest(s, int'(age_rank[s]));
        end
        held_key[s] = t;
        present[s]  = 1'b1;
      end
      r.hit  = found;
      r.slot = lsc_pkg::SLOT_PORT_W'(s);
      pending_lookups = {pending_lookups, r};
    endfunction

    task report(string what, logic [lsc_pkg::KEY_PORT_W-1:0] got,
                logic [lsc_pkg::KEY_PORT_W-1:0] want);
      $display("[%0t] mismatch on %s at beat %0d: got %h, expected %h",
               $realtime, what, beats_seen, got, want);
      mismatches++;
    endtask

    task check_result(logic hit, logic [lsc_pkg::SLOT_PORT_W-1:0] slot, logic ev_valid,
                      logic [lsc_pkg::KEY_PORT_W-1:0] ev_key);
      lookup_res_t want;
      beats_seen++;
      if (pending_lookups.size() == 0) begin
        report("unrequested beat", lsc_pkg::KEY_PORT_W'({hit, slot, ev_valid}), '0);
      end else begin
        want = pending_lookups.pop_front();
        if (hit !== want.hit)
          report("hit", lsc_pkg::KEY_PORT_W'(hit), lsc_pkg::KEY_PORT_W'(want.hit));
        if (slot !== want.slot)
          report("slot", lsc_pkg::KEY_PORT_W'(slot), lsc_pkg::KEY_PORT_W'(want.slot));
        if (ev_valid !== want.ev_valid)
          report("evicted_valid", lsc_pkg::KEY_PORT_W'(ev_valid),
                 lsc_pkg::KEY_PORT_W'(want.ev_valid));
        if (ev_key !== want.ev_key)     report("evicted_key", ev_key, want.ev_key);
      end
    endtask
  endclass

  logic clk;
  logic rst;

  lsc_key_if req_ch ();
  lsc_res_if rsp_ch ();

  lru_slot_cache u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  lru_shadow tracker;
  int        burst_left    = 0;
  bit        long_hold_req = 1'b0;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Offer one key and hold it until accepted. The sender runs in bursts;
  // when a burst runs out valid drops for a random gap. Long bursts give
  // stretches with no idling at all.
  task automatic offer_key(input logic [lsc_pkg::KEY_PORT_W-1:0] k);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 30);
    end
    burst_left--;
    req_ch.valid <= 1'b1;
    req_ch.key   <= k;
    do @(posedge clk); while (!req_ch.ready);
    tracker.note_key(k);
    @(negedge clk);
  endtask

  // Stop offering and wait until every queued response has come back.
  // The extra edge keeps valid from being lowered and raised in one step.
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  // Response pacing: random-length runs in one of several stall patterns,
  // from always-ready to mostly-stalled. On request, one long hold-off so
  // the output register and the pending commit fill and req.ready drops.
  initial begin : rsp_pacer
    int mode;
    int run_len;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      mode    = $urandom_range(0, 3);
      run_len = $urandom_range(10, 120);
      repeat (run_len) begin
        case (mode)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
          2: rsp_ch.ready <= 1'($urandom_range(0, 1));
          default: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
        @(negedge clk);
      end
    end
  end

  // Response monitor: every accepted beat is checked against the oldest
  // queued lookup.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      tracker.check_result(rsp_ch.hit, rsp_ch.slot, rsp_ch.evicted_valid,
                           rsp_ch.evicted_key);
    end
  end

  initial begin : stimulus
    logic [lsc_pkg::KEY_PORT_W-1:0] directed_keys [$];
    int                             pool_size [PHASES];
    bit                             sweep     [PHASES];
    logic [lsc_pkg::KEY_PORT_W-1:0] key_pool  [64];
    logic [lsc_pkg::KEY_PORT_W-1:0] k;
    int                             pick;
    int                             sweep_idx;

    tracker      = new();
    req_ch.valid = 1'b0;
    req_ch.key   = '0;
    rst          = 1'b1;

    // Directed: all-zero and all-one keys, hits on both, then fill every
    // empty slot in order, then misses on a full store that evict the LRU
    // entry, a hit on an old entry, and misses on keys evicted earlier.
    directed_keys = '{32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'h0000_0000,
                      32'h0000_0001, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555,
                      32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'h0000_FFFF, 32'hFFFF_0000,
                      32'h1234_5678, 32'h8765_4321, 32'h0000_0002, 32'h4000_0000,
                      32'h0F0F_0F0F, 32'hF0F0_F0F0,
                      32'hC3C3_C3C3, 32'h0000_0001, 32'hFFFF_FFFF, 32'h3C3C_3C3C,
                      32'h0000_0000};

    // Working sets around the store size. Sweep phases walk the set in
    // order: 16 keys settle into hits, 17 keys evict on every access.
    pool_size = '{4, 16, 17, 12, 32, 8, 20, 64};
    sweep     = '{0, 1, 1, 0, 0, 1, 0, 0};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_keys[i]) offer_key(directed_keys[i]);
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      for (int j = 0; j < pool_size[p]; j++) key_pool[j] = $urandom();
      if (p == 2) long_hold_req = 1'b1;   // sender keeps offering meanwhile
      if (p == 4) wait_idle();            // full drain mid-run
      sweep_idx = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (sweep[p] && pick < 85) begin
          k         = key_pool[sweep_idx];
          sweep_idx = (sweep_idx + 1) % pool_size[p];
        end else if (pick < 80) begin
          k = key_pool[$urandom_range(0, pool_size[p] - 1)];
        end else if (pick < 92) begin
          // near miss: one bit off a held key
          k = key_pool[$urandom_range(0, pool_size[p] - 1)] ^ (32'h1 << $urandom_range(0, 31));
        end else begin
          k = $urandom();
        end
        offer_key(k);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (tracker.mismatches == 0) begin
      $display("** lru_slot_cache: PASSED **");
    end else begin
      $display("** lru_slot_cache: FAILED **");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin : watchdog
    #2_000_000;
    $display("** lru_slot_cache: FAILED **");
    $finish;
  end

endmodule
